// ----- src/mm4_pkg.sv -----
// Shared constants and types for the 4x4 fixed-point matrix multiply unit.
// No dependencies; imported by the lane, merge and top-level modules.
package mm4_pkg;

  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam int ELEM_W   = 32;
  localparam int ROW_W    = 2;
  localparam int NCARRIED = 4;
  localparam int PROD_W   = 2 * ELEM_W;

  // Stream payload widths, padded up to whole bytes.
  localparam int TDATA_BITS = ROW_W + NCARRIED * ELEM_W;
  localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MUL  = 1'b1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [ROW_W-1:0]         row_t;

  // Load enables from the pipeline control to each lane.
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctrl_t;

endpackage

// ----- src/matrix_multiply_4x4_unit.sv -----
// Fixed-point (Q16.16) 4x4 matrix multiply, one matrix row per transaction.
// A multiply transaction's result row passes through the product register,
// the sum register and the output register before it shows.
// Throughput: one transaction per cycle while the output is not stalled, loads and
// multiplies alike; the four column lanes each hold DIM multipliers, so a whole row issues at once.
// Reset clears only pipeline valid bits; the stored right matrix is undefined until loaded.
module matrix_multiply_4x4_unit
  import mm4_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream. tdata from bit 0 up: row[1:0], elem_0, elem_1, elem_2,
  // elem_3 (32 bits each), zero padding. tuser: op (0 load, 1 multiply).
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]         s_axis_tuser,
  // Output stream. tdata from bit 0 up: out_row[1:0], out_0, out_1, out_2,
  // out_3 (32 bits each), zero padding. tuser: saturated.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]         m_axis_tuser
);

  localparam int SUM_W = PROD_W + $clog2(DIM);

  // Stored right matrix, indexed [row][column]. Each entry feeds one fixed
  // multiplier, so it lives in plain registers without reset.
  elem_t rm_q [DIM][DIM];

  elem_t a_row [DIM];
  row_t  in_row;
  logic  row_ok;
  logic  accept;
  logic  mul_in;
  logic  load_in;

  logic  v1_q, v2_q;
  row_t  row1_q, row2_q;
  logic  ready1, ready2, ready3;

  lane_ctrl_t              lane_ctrl;
  logic signed [SUM_W-1:0] lane_sum [NCARRIED];

  // Unpack the left (or loaded) row. With DIM above four, the elements
  // that are not carried count as zero.
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      if (k < NCARRIED) begin
        a_row[k] = s_axis_tdata[ROW_W + k*ELEM_W +: ELEM_W];
      end else begin
        a_row[k] = '0;
      end
    end
  end

  assign in_row  = s_axis_tdata[ROW_W-1:0];
  assign row_ok  = int'(in_row) < DIM;

  // Pipeline control: each stage advances when empty or when the next one
  // advances, so bubbles close up while the output waits.
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;
  assign s_axis_tready = ready1;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign mul_in  = accept && (s_axis_tuser[0] == OP_MUL) && row_ok;
  assign load_in = accept && (s_axis_tuser[0] == OP_LOAD) && row_ok;

  assign lane_ctrl.ld_prod = mul_in;
  assign lane_ctrl.ld_sum  = v1_q && ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= mul_in;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_in) begin
      row1_q <= in_row;
    end
    if (lane_ctrl.ld_sum) begin
      row2_q <= row1_q;
    end
  end

  // A load writes one matrix row. A multiply captures its products from the
  // contents as they stand when it is accepted, so a later load cannot change
  // its result, which keeps transaction order.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < DIM; r++) begin
      if (load_in && (int'(in_row) == r)) begin
        for (int k = 0; k < DIM; k++) begin
          rm_q[r][k] <= a_row[k];
        end
      end
    end
  end

  // One lane per output column; columns at or beyond DIM read as zero.
  for (genvar j = 0; j < NCARRIED; j++) begin : g_lane
    if (j < DIM) begin : g_active
      elem_t col [DIM];

      always_comb begin
        for (int k = 0; k < DIM; k++) begin
          col[k] = rm_q[k][j];
        end
      end

      mm4_lane #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
      ) u_lane (
        .clk_i  (clk_i),
        .ctrl_i (lane_ctrl),
        .a_i    (a_row),
        .b_i    (col),
        .sum_o  (lane_sum[j])
      );
    end else begin : g_zero
      assign lane_sum[j] = '0;
    end
  end

  mm4_merge #(
    .DIM   (DIM),
    .SUM_W (SUM_W)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v2_q),
    .in_ready_o    (ready3),
    .row_i         (row2_q),
    .sum_i         (lane_sum),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- src/mm4_lane.sv -----
// One column lane: DIM registered products, then the floor-shifted sum.
// Depends on mm4_pkg.
module mm4_lane
  import mm4_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SUM_W     = PROD_W + $clog2(DIM)
) (
  input  logic                    clk_i,
  input  lane_ctrl_t              ctrl_i,
  input  elem_t                   a_i   [DIM],
  input  elem_t                   b_i   [DIM],
  output logic signed [SUM_W-1:0] sum_o
);

  prod_t                   prod_q [DIM];
  logic signed [SUM_W-1:0] sum_d;
  logic signed [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod) begin
      for (int k = 0; k < DIM; k++) begin
        prod_q[k] <= prod_t'(a_i[k]) * prod_t'(b_i[k]);
      end
    end
  end

  // Each product is shifted toward minus infinity before the exact sum.
  always_comb begin
    prod_t sh;
    sum_d = '0;
    for (int k = 0; k < DIM; k++) begin
      sh    = prod_q[k] >>> FRAC_BITS;
      sum_d = sum_d + {{(SUM_W-PROD_W){sh[PROD_W-1]}}, sh};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_sum) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- src/mm4_merge.sv -----
// Merge stage: saturates each lane sum to 32 bits, ORs the saturation flags
// and holds the result row in the output register. Depends on mm4_pkg.
module mm4_merge
  import mm4_pkg::*;
#(
  parameter int DIM   = DIM_DEF,
  parameter int SUM_W = PROD_W + $clog2(DIM)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  row_t                    row_i,
  input  logic signed [SUM_W-1:0] sum_i [NCARRIED],
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,
  output logic [0:0]              m_axis_tuser
);

  logic                  valid_q;
  logic [TDATA_W-1:0]    data_d;
  logic [TDATA_W-1:0]    data_q;
  logic                  sat_d;
  logic                  sat_q;

  assign in_ready_o = !valid_q || m_axis_tready;

  always_comb begin
    logic fits;
    elem_t res;
    data_d = '0;
    sat_d  = 1'b0;
    data_d[ROW_W-1:0] = row_i;
    for (int j = 0; j < NCARRIED; j++) begin
      fits = (sum_i[j][SUM_W-1:ELEM_W-1] == '0) || (sum_i[j][SUM_W-1:ELEM_W-1] == '1);
      if (fits) begin
        res = sum_i[j][ELEM_W-1:0];
      end else if (sum_i[j][SUM_W-1]) begin
        res = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
        res = {1'b0, {(ELEM_W-1){1'b1}}};
      end
      sat_d = sat_d | !fits;
      data_d[ROW_W + j*ELEM_W +: ELEM_W] = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
      sat_q  <= sat_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = sat_q;

endmodule
